FILE: rtl/kea_pkg.sv
// kea_pkg: shared types and constants for the kruskal edge acceptor
// no dependencies; used by kruskal_edge_acceptor, its checker and tb_top

package kea_pkg;

  localparam int MAX_NODES = 255;
  localparam int NODE_W    = $clog2(MAX_NODES + 1);
  localparam int DEPTH     = MAX_NODES + 1;
  localparam int ID_W      = 8;
  localparam int RANK_W    = 4;
  localparam int CMP_W     = 16;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_EDGE  = 1'b1;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] node_a;
    logic [ID_W-1:0] node_b;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    logic bad_node;
  } result_t;

endpackage

FILE: rtl/kruskal_edge_acceptor.sv
// kruskal_edge_acceptor: union-find store for minimum spanning tree edge selection
// depends on kea_pkg (types, widths, action codes)

// Items are taken when start is high and busy is low. An edge with a bad
// endpoint (zero or above node_count) is answered without a walk, busy stays
// low and done pulses with the result on the next cycle. A good edge walks the
// parent chain of node_a, then of node_b, through one link/rank memory with a
// single registered read port, one link per cycle, with busy high from the
// accept until the root of node_b is found. Unions go by rank, so the number of
// links from a node to its root never exceeds 7 with 255 nodes. A clear item
// rewrites every entry of the link and rank memories, one entry per cycle, with
// busy high, and done pulses in the cycle after the last entry is written. The
// same clearing pass runs after reset, with busy high and no result. Each
// result is on done for exactly one cycle and cannot be held off; the next item
// may start in that same cycle.

module kruskal_edge_acceptor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  kea_pkg::cmd_t        cmd,
  output logic                 done,
  output kea_pkg::result_t     result,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND_A,
    S_FIND_B,
    S_CLEAR
  } state_t;

  state_t state;

  // configuration
  logic [7:0] node_count;

  // link and rank memories, one read address, registered read
  logic [kea_pkg::NODE_W-1:0] link_mem [kea_pkg::DEPTH];
  logic [kea_pkg::RANK_W-1:0] rank_mem [kea_pkg::DEPTH];

  logic [kea_pkg::NODE_W-1:0] raddr;
  logic [kea_pkg::NODE_W-1:0] link_q;
  logic [kea_pkg::RANK_W-1:0] rank_q;

  // walk registers
  logic [kea_pkg::NODE_W-1:0] cur;
  logic [kea_pkg::NODE_W-1:0] node_b_reg;
  logic [kea_pkg::NODE_W-1:0] root_a;
  logic [kea_pkg::RANK_W-1:0] rank_a;

  // clearing pass: entry counter, and whether a clear item waits for its result
  logic [kea_pkg::NODE_W-1:0] clr_addr;
  logic                       clr_reply;
  logic                       clr_last;

  // derived walk values
  logic [kea_pkg::NODE_W-1:0] parent;
  logic [kea_pkg::RANK_W-1:0] cur_rank;
  logic                       at_root;

  // memory write controls
  logic                       link_we;
  logic [kea_pkg::NODE_W-1:0] link_waddr;
  logic [kea_pkg::NODE_W-1:0] link_wdata;
  logic                       rank_we;
  logic [kea_pkg::NODE_W-1:0] rank_waddr;
  logic [kea_pkg::RANK_W-1:0] rank_wdata;

  // endpoint range check
  logic [kea_pkg::CMP_W-1:0] limit;
  logic [kea_pkg::CMP_W-1:0] a_ext;
  logic [kea_pkg::CMP_W-1:0] b_ext;
  logic                      bad;
  logic                      accept;
  logic                      done_next;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign clr_last = (clr_addr == kea_pkg::NODE_W'(kea_pkg::MAX_NODES));

  always_comb begin
    if (kea_pkg::CMP_W'(node_count) > kea_pkg::CMP_W'(kea_pkg::MAX_NODES)) begin
      limit = kea_pkg::CMP_W'(kea_pkg::MAX_NODES);
    end else begin
      limit = kea_pkg::CMP_W'(node_count);
    end
    a_ext = kea_pkg::CMP_W'(cmd.node_a);
    b_ext = kea_pkg::CMP_W'(cmd.node_b);
    bad   = (a_ext == '0) || (b_ext == '0) || (a_ext > limit) || (b_ext > limit);
  end

  always_comb begin
    parent   = link_q;
    cur_rank = rank_q;
    at_root  = (parent == cur);
  end

  // read address: start of walk a, step of a walk, or jump to walk b
  always_comb begin
    unique case (state)
      S_IDLE:   raddr = kea_pkg::NODE_W'(cmd.node_a);
      S_FIND_A: raddr = at_root ? node_b_reg : parent;
      S_FIND_B: raddr = parent;
      default:  raddr = parent;
    endcase
  end

  // result strobe: bad edge next cycle, good edge at the end of walk b,
  // clear item at the end of its pass
  always_comb begin
    unique case (state)
      S_IDLE:   done_next = accept && (cmd.action == kea_pkg::ACT_EDGE) && bad;
      S_FIND_B: done_next = at_root;
      S_CLEAR:  done_next = clr_last && clr_reply;
      default:  done_next = 1'b0;
    endcase
  end

  // clearing pass, or union by rank once both roots are known and differ
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = root_a;
    rank_we    = 1'b0;
    rank_waddr = root_a;
    rank_wdata = rank_a + kea_pkg::RANK_W'(1);
    if (state == S_CLEAR) begin
      // one entry per cycle back to a self link with rank zero
      link_we    = 1'b1;
      link_waddr = clr_addr;
      link_wdata = clr_addr;
      rank_we    = 1'b1;
      rank_waddr = clr_addr;
      rank_wdata = '0;
    end else if (state == S_FIND_B && at_root && cur != root_a) begin
      link_we = 1'b1;
      if (rank_a < cur_rank) begin
        // root a hangs under root b
        link_waddr = root_a;
        link_wdata = cur;
      end else begin
        // root b hangs under root a, equal ranks grow a
        link_waddr = cur;
        link_wdata = root_a;
        rank_we    = (rank_a == cur_rank) && (rank_a != kea_pkg::RANK_MAX);
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    link_q <= link_mem[raddr];
    rank_q <= rank_mem[raddr];
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      node_count <= 8'd255;
      done       <= 1'b0;
      result     <= '0;
    end else begin
      done <= done_next;
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.action == kea_pkg::ACT_CLEAR) begin
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end else if (bad) begin
              result.accepted <= 1'b0;
              result.bad_node <= 1'b1;
            end else begin
              cur        <= kea_pkg::NODE_W'(cmd.node_a);
              node_b_reg <= kea_pkg::NODE_W'(cmd.node_b);
              state      <= S_FIND_A;
            end
          end
        end
        S_FIND_A: begin
          if (at_root) begin
            root_a <= cur;
            rank_a <= cur_rank;
            cur    <= node_b_reg;
            state  <= S_FIND_B;
          end else begin
            cur <= parent;
          end
        end
        S_FIND_B: begin
          if (at_root) begin
            result.accepted <= (cur != root_a);
            result.bad_node <= 1'b0;
            state           <= S_IDLE;
          end else begin
            cur <= parent;
          end
        end
        S_CLEAR: begin
          if (clr_last) begin
            result    <= '0;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + kea_pkg::NODE_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/kea_checker.sv
// kea_checker: port-level assertions for kruskal_edge_acceptor, bound into every instance of that module
// depends on kea_pkg and kruskal_edge_acceptor

module kea_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input kea_pkg::cmd_t    cmd,
  input logic             done,
  input kea_pkg::result_t result
);

  // a result always lands with the block free for the next item
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // a clear item starts its clearing pass, no result on the next cycle
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.action == kea_pkg::ACT_CLEAR)
      |=> (busy && !done))
    else $error("clear item did not start its pass");

  // a zero endpoint is flagged next cycle and never accepted
  a_zero_node: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.action == kea_pkg::ACT_EDGE &&
     (cmd.node_a == '0 || cmd.node_b == '0))
      |=> (done && result.bad_node && !result.accepted))
    else $error("zero endpoint not flagged");

  // an edge is never both accepted and flagged
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.accepted && result.bad_node))
    else $error("accepted and bad_node together");

endmodule

bind kruskal_edge_acceptor kea_checker u_kea_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);

FILE: sim/tb_top.sv
// tb_top: self-checking testbench for the kruskal edge acceptor
// depends on kea_pkg and kruskal_edge_acceptor; holds its own union-find predictor

module tb_top;

  // clock, reset and block ports
  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  kea_pkg::cmd_t     cmd;
  logic              done;
  kea_pkg::result_t  result;
  logic              cfg_we;
  logic [7:0]        cfg_wdata;

  // predictor copy of the union-find store and the node count register
  logic [kea_pkg::ID_W-1:0]   uf_parent [0:kea_pkg::MAX_NODES];
  logic [kea_pkg::RANK_W-1:0] uf_rank   [0:kea_pkg::MAX_NODES];
  logic [7:0]                 tree_node_count;

  // verdicts still owed by the block, oldest first
  kea_pkg::result_t pending_verdicts [$];
  int unsigned      verdict_errors;
  int unsigned      gap_ceiling;

  kruskal_edge_acceptor dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // every node back in a set of its own
  function automatic void clear_forest();
    for (int i = 0; i <= kea_pkg::MAX_NODES; i++) begin
      uf_parent[i] = kea_pkg::ID_W'(i);
      uf_rank[i]   = '0;
    end
  endfunction

  // walk parent links up to the root
  function automatic logic [kea_pkg::ID_W-1:0] root_of(logic [kea_pkg::ID_W-1:0] node);
    logic [kea_pkg::ID_W-1:0] cur;
    cur = node;
    for (int k = 0; k <= kea_pkg::MAX_NODES; k++) begin
      if (uf_parent[cur] == cur) break;
      cur = uf_parent[cur];
    end
    return cur;
  endfunction

  // verdict of one item, applying its effect on the predicted store
  function automatic kea_pkg::result_t predict_verdict(kea_pkg::cmd_t item);
    kea_pkg::result_t         verdict;
    int unsigned              limit;
    logic [kea_pkg::ID_W-1:0] root_a;
    logic [kea_pkg::ID_W-1:0] root_b;
    verdict = '0;
    limit   = tree_node_count;
    if (limit > kea_pkg::MAX_NODES) limit = kea_pkg::MAX_NODES;
    if (item.action == kea_pkg::ACT_CLEAR) begin
      clear_forest();
      return verdict;
    end
    // zero or out-of-range endpoint: flagged, store untouched
    if (item.node_a == 0 || item.node_b == 0 ||
        item.node_a > limit || item.node_b > limit) begin
      verdict.bad_node = 1'b1;
      return verdict;
    end
    root_a = root_of(item.node_a);
    root_b = root_of(item.node_b);
    // same set, self loops included: edge would close a cycle
    if (root_a == root_b) return verdict;
    // union by rank, ties hang b under a and bump a's rank
    if (uf_rank[root_a] < uf_rank[root_b]) begin
      uf_parent[root_a] = root_b;
    end else if (uf_rank[root_a] > uf_rank[root_b]) begin
      uf_parent[root_b] = root_a;
    end else begin
      uf_parent[root_b] = root_a;
      if (uf_rank[root_a] != kea_pkg::RANK_MAX) uf_rank[root_a] = uf_rank[root_a] + 1'b1;
    end
    verdict.accepted = 1'b1;
    return verdict;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking: done is a one-cycle strobe, sampled at the edge ending it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    kea_pkg::result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        if (verdict_errors < 10)
          $display("unexpected result: accepted=%b bad_node=%b", result.accepted,
                   result.bad_node);
        verdict_errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (result.accepted !== want.accepted || result.bad_node !== want.bad_node) begin
          if (verdict_errors < 10)
            $display("mismatch: accepted exp %b got %b, bad_node exp %b got %b",
                     want.accepted, result.accepted, want.bad_node, result.bad_node);
          verdict_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // present one item after a random gap and hold it until the block takes it;
  // start stays high on return so a back-to-back item needs no extra toggle
  task automatic offer_cmd(input kea_pkg::cmd_t item);
    int unsigned gap;
    gap = $urandom_range(0, gap_ceiling);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_verdicts.insert(pending_verdicts.size(), predict_verdict(item));
  endtask

  task automatic offer_edge(input logic [kea_pkg::ID_W-1:0] a,
                            input logic [kea_pkg::ID_W-1:0] b);
    kea_pkg::cmd_t item;
    item.action = kea_pkg::ACT_EDGE;
    item.node_a = a;
    item.node_b = b;
    offer_cmd(item);
  endtask

  // clear item, id fields carry random junk
  task automatic offer_clear();
    kea_pkg::cmd_t item;
    item.action = kea_pkg::ACT_CLEAR;
    item.node_a = kea_pkg::ID_W'($urandom);
    item.node_b = kea_pkg::ID_W'($urandom);
    offer_cmd(item);
  endtask

  // drop start and wait for every owed verdict
  task automatic drain_verdicts();
    start <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // register write only with the block idle
  task automatic write_node_count(input logic [7:0] value);
    drain_verdicts();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tree_node_count = value;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked edges at the reset node count of 255
  task automatic test_directed_edges();
    gap_ceiling = 3;
    offer_edge(8'd1, 8'd2);      // plain merge
    offer_edge(8'd2, 8'd1);      // same set, rejected
    offer_edge(8'd0, 8'd5);      // zero endpoint a
    offer_edge(8'd5, 8'd0);      // zero endpoint b
    offer_edge(8'd0, 8'd0);
    offer_edge(8'd255, 8'd255);  // self loop at top id
    offer_edge(8'd255, 8'd1);    // lower rank hangs under higher
    offer_edge(8'd3, 8'd4);      // equal ranks
    offer_edge(8'd1, 8'd3);      // equal ranks one level up
    offer_edge(8'd4, 8'd7);      // higher rank absorbs singleton
    offer_edge(8'd170, 8'd85);   // alternating bit patterns
    offer_edge(8'd4, 8'd255);    // deep walks on both sides, same set
    offer_clear();
    offer_edge(8'd1, 8'd2);      // sets restored by the clear
    offer_edge(8'd128, 8'd127);
    offer_edge(8'd2, 8'd128);
  endtask

  // node count at its extremes and around small sizes
  task automatic test_node_count_limits();
    gap_ceiling = 3;
    write_node_count(8'd0);      // every id bad
    offer_edge(8'd1, 8'd1);
    offer_edge(8'd255, 8'd255);
    offer_edge(8'd1, 8'd2);
    write_node_count(8'd1);
    offer_edge(8'd1, 8'd1);      // only self loop possible
    offer_edge(8'd1, 8'd2);
    offer_edge(8'd2, 8'd1);
    write_node_count(8'd2);
    offer_edge(8'd2, 8'd1);
    offer_edge(8'd1, 8'd3);
    write_node_count(8'd254);
    offer_edge(8'd254, 8'd255);
    offer_edge(8'd253, 8'd254);
    write_node_count(8'd255);
    offer_edge(8'd255, 8'd254);
  endtask

  // shrinking the node count keeps links that point past the new range
  task automatic test_shrink_keeps_links();
    gap_ceiling = 0;
    write_node_count(8'd255);
    offer_clear();
    for (int i = 1; i <= 10; i++) offer_edge(8'(200 + i), 8'(i));
    offer_edge(8'd201, 8'd202);
    offer_edge(8'd205, 8'd210);
    write_node_count(8'd10);
    offer_edge(8'd1, 8'd2);      // roots may sit above the range
    offer_edge(8'd3, 8'd4);
    offer_edge(8'd6, 8'd10);
    offer_edge(8'd11, 8'd1);     // just past the range
    offer_edge(8'd5, 8'd9);
  endtask

  // random forests: mostly good edges inside the range, some bad ids and clears
  task automatic test_random_forests();
    logic [7:0]               nc;
    logic [kea_pkg::ID_W-1:0] a;
    logic [kea_pkg::ID_W-1:0] b;
    int unsigned              pick;
    int unsigned              items;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0:       nc = 8'd255;
        1:       nc = 8'd2;
        2:       nc = 8'd6;
        3:       nc = 8'd16;
        4:       nc = 8'd255;
        5:       nc = 8'd1;
        default: nc = 8'($urandom_range(1, 255));
      endcase
      // odd phases run without gaps
      gap_ceiling = (phase % 2 == 1) ? 0 : 3;
      items = (nc > 100) ? 70 : 30;
      write_node_count(nc);
      // most phases start clean, some keep the old forest
      if ($urandom_range(0, 3) != 0) offer_clear();
      for (int n = 0; n < items; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          offer_clear();
        end else if (pick < 14) begin
          // one endpoint zero or beyond the range, the other anything
          if (nc == 8'd255 || $urandom_range(0, 1) == 0) a = '0;
          else a = kea_pkg::ID_W'($urandom_range(nc + 1, 255));
          b = kea_pkg::ID_W'($urandom);
          if ($urandom_range(0, 1) != 0) offer_edge(a, b);
          else offer_edge(b, a);
        end else begin
          a = kea_pkg::ID_W'($urandom_range(1, nc));
          b = kea_pkg::ID_W'($urandom_range(1, nc));
          offer_edge(a, b);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    gap_ceiling = 0;
    verdict_errors  = 0;
    tree_node_count = 8'd255;
    clear_forest();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_node_count_limits();
    test_shrink_keeps_links();
    test_random_forests();

    drain_verdicts();
    // room for any stray strobe after the last verdict
    repeat (40) @(posedge clk);
    if (verdict_errors == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
